// ----- sv/lir_pkg.sv -----
// shared types and constants of the linear interpolation resampler
package lir_pkg;

    localparam int STEP_W     = 21;
    localparam int CHAN_W     = 2;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 1'd1;

    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;

    typedef struct packed {
        logic valid;
        logic last_of_run;
        logic end_of_stream;
        logic stereo;
    } res_ctl_t;

endpackage

// ----- sv/lir_lane.sv -----
// one channel lane: registered difference times fraction, then base plus floor of product
module lir_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] base,
    input  logic signed [SAMPLE_BITS-1:0] target,
    input  logic        [FRAC_BITS-1:0]   frac,
    output logic        [SAMPLE_BITS-1:0] result
);

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic        [SAMPLE_BITS-1:0] base_reg;

    assign diff      = {target[SAMPLE_BITS-1], target} - {base[SAMPLE_BITS-1], base};
    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            base_reg <= base;
        end
    end

    // arithmetic shift gives the floor, only the low sample bits survive
    assign result = base_reg + prod_reg[FRAC_BITS +: SAMPLE_BITS];

endmodule

// ----- sv/lir_merge.sv -----
// merge stage: collects the lane results into the registered output word
module lir_merge #(
    parameter int MAX_CHANNELS = 2,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  lir_pkg::res_ctl_t                         issue_ctl,
    input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]  lane_result,
    output logic                                      adv,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [SAMPLE_BITS-1:0]             m_out_left,
    output logic signed [SAMPLE_BITS-1:0]             m_out_right,
    output logic                                      m_last_of_run,
    output logic                                      m_end_of_stream
);

    import lir_pkg::*;

    res_ctl_t                s1_ctl_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  left_reg;
    logic [SAMPLE_BITS-1:0]  right_reg;
    logic [SAMPLE_BITS-1:0]  right_next;
    logic                    lor_reg;
    logic                    eos_reg;

    assign adv = !out_valid_reg || m_ready;

    generate
        if (MAX_CHANNELS > 1) begin : g_stereo
            assign right_next = s1_ctl_reg.stereo ? lane_result[1] : '0;
        end else begin : g_mono
            assign right_next = '0;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_ctl_reg    <= issue_ctl;
            out_valid_reg <= s1_ctl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_reg  <= lane_result[0];
            right_reg <= right_next;
            lor_reg   <= s1_ctl_reg.last_of_run;
            eos_reg   <= s1_ctl_reg.end_of_stream;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_left      = left_reg;
    assign m_out_right     = right_reg;
    assign m_last_of_run   = lor_reg;
    assign m_end_of_stream = eos_reg;

endmodule

// ----- sv/linear_interp_resampler_top.sv -----
// linear interpolation resampler: phase sequencer, per-channel lanes and merge stage
// path: sequencer issue, then lane product registers, then merge output registers
// throughput: one result word per cycle while the output is not stalled; s_ready is low, and
// no new input word is taken, until the sequencer has issued every result of the last word
// and is idle again
// reset: phase, held frame and stream flag clear; step 1.0 and stereo are selected
module linear_interp_resampler_top #(
    parameter int MAX_CHANNELS    = 2,
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_right,
    input  logic                             s_last_frame,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_out_left,
    output logic signed [SAMPLE_BITS-1:0]    m_out_right,
    output logic                             m_last_of_run,
    output logic                             m_end_of_stream
);

    import lir_pkg::*;

    localparam int PW = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 2;
    localparam logic [PW-1:0]      PHASE_ONE  = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_FLOOR =
        STEP_W'(1) << (PHASE_FRAC_BITS - $clog2(RESULT_CAP));
    localparam logic [CNT_W-2:0]   CNT_LAST   = (CNT_W-1)'(RESULT_CAP - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INTERP = 2'd1;
    localparam logic [1:0] ST_TAIL   = 2'd2;

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

    logic [STEP_W-1:0]  step_cfg_reg;
    logic [CHAN_W-1:0]  chan_cfg_reg;

    logic [1:0]         state_reg,  state_next;
    logic [PW-1:0]      phase_reg,  phase_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               seen_reg,   seen_next;
    frame_t             held_reg,   held_next;
    frame_t             new_reg,    new_next;
    logic [STEP_W-1:0]  step_reg,   step_next;
    logic               stereo_reg, stereo_next;
    logic               last_reg,   last_next;

    frame_t             in_frame;
    frame_t             lane_result;
    logic [STEP_W-1:0]  step_eff;
    logic               stereo_cfg;
    logic [PW-1:0]      np;
    logic [PW-1:0]      p_end;
    logic [PW-1:0]      wrap_p;
    logic               can_emit;
    logic               cnt_not_last;
    logic               more_run;
    logic               more_tail;
    logic               adv;
    logic               issue;
    res_ctl_t           issue_ctl;

    assign step_eff   = (step_cfg_reg < STEP_FLOOR) ? STEP_FLOOR : step_cfg_reg;
    assign stereo_cfg = (MAX_CHANNELS > 1) && (chan_cfg_reg != CHAN_MONO);

    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (c == 0) begin
                in_frame[c] = s_sample_left;
            end else begin
                in_frame[c] = stereo_cfg ? s_sample_right : '0;
            end
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign np           = phase_reg + PW'(step_reg);
    assign can_emit     = (phase_reg < PHASE_ONE) && !cnt_reg[CNT_W-1];
    assign issue        = ((state_reg == ST_INTERP) || (state_reg == ST_TAIL)) && can_emit && adv;
    assign p_end        = issue ? np : phase_reg;
    assign wrap_p       = (p_end >= PHASE_ONE) ? (p_end - PHASE_ONE) : '0;
    assign cnt_not_last = (cnt_reg[CNT_W-2:0] != CNT_LAST);
    assign more_run     = (np < PHASE_ONE) && cnt_not_last;
    assign more_tail    = last_reg && (wrap_p < PHASE_ONE) && cnt_not_last;

    always_comb begin
        issue_ctl.valid  = issue;
        issue_ctl.stereo = stereo_reg;
        if (state_reg == ST_TAIL) begin
            issue_ctl.last_of_run   = !more_run;
            issue_ctl.end_of_stream = !more_run;
        end else begin
            issue_ctl.last_of_run   = !more_run && !more_tail;
            issue_ctl.end_of_stream = !more_run && !more_tail && last_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        seen_next   = seen_reg;
        held_next   = held_reg;
        new_next    = new_reg;
        step_next   = step_reg;
        stereo_next = stereo_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    new_next    = in_frame;
                    step_next   = step_eff;
                    stereo_next = stereo_cfg;
                    last_next   = s_last_frame;
                    cnt_next    = '0;
                    if (seen_reg) begin
                        state_next = ST_INTERP;
                    end else begin
                        seen_next = 1'b1;
                        held_next = in_frame;
                        if (s_last_frame) begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_INTERP: begin
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (issue && more_run) begin
                    phase_next = np;
                end else if (issue || !can_emit) begin
                    phase_next = wrap_p;
                    held_next  = new_reg;
                    state_next = last_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (issue && more_run) begin
                    phase_next = np;
                end else if (issue || !can_emit) begin
                    phase_next = '0;
                    seen_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            seen_reg     <= 1'b0;
            held_reg     <= '0;
            step_cfg_reg <= STEP_RESET;
            chan_cfg_reg <= CHAN_RESET;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            held_reg  <= held_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_STEP_RATIO: step_cfg_reg <= cfg_wdata[STEP_W-1:0];
                    CFG_CHANNELS:   chan_cfg_reg <= cfg_wdata[CHAN_W-1:0];
                    default:        step_cfg_reg <= step_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        new_reg    <= new_next;
        step_reg   <= step_next;
        stereo_reg <= stereo_next;
        last_reg   <= last_next;
    end

    generate
        for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
            lir_lane #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .FRAC_BITS   (PHASE_FRAC_BITS)
            ) u_lane (
                .aclk   (aclk),
                .en     (adv),
                .base   (held_reg[g]),
                .target (new_reg[g]),
                .frac   (phase_reg[PHASE_FRAC_BITS-1:0]),
                .result (lane_result[g])
            );
        end
    endgenerate

    lir_merge #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .issue_ctl       (issue_ctl),
        .lane_result     (lane_result),
        .adv             (adv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_stream (m_end_of_stream)
    );

    a_eos_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_stream |-> m_last_of_run)
        else $error("end of stream word without last of run");

    a_tail_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) && !can_emit |=> !seen_reg && (phase_reg == '0))
        else $error("stream did not re-arm after tail");

    a_cnt_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        !cnt_reg[CNT_W-1] || (cnt_reg[CNT_W-2:0] == '0))
        else $error("result count beyond cap");

    a_interp_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INTERP) |-> seen_reg)
        else $error("interpolation without held frame");

    a_first_frame_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !seen_reg |-> (phase_reg == '0))
        else $error("stream starts with nonzero phase");

endmodule

// ----- test/resample_check_pkg.sv -----
// scoreboard class that predicts and checks resampler output words
package resample_check_pkg;

    import lir_pkg::*;

    localparam int        FRAC_BITS  = 16;
    localparam bit [31:0] PHASE_ONE  = 32'd1 << FRAC_BITS;
    localparam bit [31:0] STEP_FLOOR = PHASE_ONE / RESULT_CAP;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        run_end;
        logic        stream_end;
    } out_word_t;

    class resample_checker;
        int                errors;
        int                held_left;
        int                held_right;
        bit [31:0]         src_phase;
        bit                in_stream;
        bit [STEP_W-1:0]   step_reg;
        bit [CHAN_W-1:0]   chan_reg;
        out_word_t         due_words[$];

        function new();
            errors     = 0;
            held_left  = 0;
            held_right = 0;
            src_phase  = '0;
            in_stream  = 1'b0;
            step_reg   = STEP_RESET;
            chan_reg   = CHAN_RESET;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_STEP_RATIO) begin
                step_reg = data[STEP_W-1:0];
            end else begin
                chan_reg = data[CHAN_W-1:0];
            end
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        // floor of the scaled difference, then back to sample width
        function logic [15:0] blend(int a, int b, bit [31:0] frac);
            longint diff;
            longint sum;
            diff = (longint'(b) - longint'(a)) * longint'(frac);
            sum  = longint'(a) + (diff >>> FRAC_BITS);
            return sum[15:0];
        endfunction

        function void take_frame(logic signed [15:0] l, logic signed [15:0] r, logic lst);
            bit        stereo;
            bit [31:0] step;
            int        nl;
            int        nr;
            int        n;
            out_word_t w;
            stereo = (chan_reg != CHAN_MONO);
            step   = (32'(step_reg) < STEP_FLOOR) ? STEP_FLOOR : 32'(step_reg);
            nl     = int'(l);
            nr     = stereo ? int'(r) : 0;
            n      = 0;
            w.run_end    = 1'b0;
            w.stream_end = 1'b0;
            if (!in_stream) begin
                in_stream = 1'b1;
            end else begin
                while (src_phase < PHASE_ONE && n < RESULT_CAP) begin
                    w.left  = blend(held_left, nl, src_phase);
                    w.right = stereo ? blend(held_right, nr, src_phase) : 16'h0000;
                    due_words.push_back(w);
                    n++;
                    src_phase += step;
                end
                src_phase = (src_phase >= PHASE_ONE) ? src_phase - PHASE_ONE : 32'd0;
            end
            held_left  = nl;
            held_right = nr;
            // end of stream: repeat the final frame until the position passes it
            if (lst) begin
                while (src_phase < PHASE_ONE && n < RESULT_CAP) begin
                    w.left  = nl[15:0];
                    w.right = nr[15:0];
                    due_words.push_back(w);
                    n++;
                    src_phase += step;
                end
                if (n > 0) begin
                    due_words[due_words.size()-1].stream_end = 1'b1;
                end
                src_phase = 32'd0;
                in_stream = 1'b0;
            end
            if (n > 0) begin
                due_words[due_words.size()-1].run_end = 1'b1;
            end
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 50) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        task check_word(logic [15:0] l, logic [15:0] r, logic lor, logic eos);
            out_word_t w;
            if (due_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %h %h lor %b eos %b", l, r, lor, eos));
                return;
            end
            w = due_words.pop_front();
            if (w.left !== l || w.right !== r || w.run_end !== lor || w.stream_end !== eos) begin
                flag_mismatch($sformatf("got %h %h lor %b eos %b, want %h %h lor %b eos %b",
                    l, r, lor, eos, w.left, w.right, w.run_end, w.stream_end));
            end
        endtask
    endclass

endpackage

// ----- test/tb_top.sv -----
// testbench top for the linear interpolation resampler with random handshakes
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;
    import resample_check_pkg::*;

    localparam int RANDOM_FRAMES  = 270;
    localparam int DRAIN_PAD      = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                        aclk            = 1'b0;
    logic                        aresetn         = 1'b0;
    logic                        cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index       = CFG_STEP_RATIO;
    logic [CFG_DATA_W-1:0]       cfg_wdata       = '0;
    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic signed [15:0]          s_sample_left   = '0;
    logic signed [15:0]          s_sample_right  = '0;
    logic                        s_last_frame    = 1'b0;
    logic                        m_valid;
    logic                        m_ready         = 1'b1;
    logic signed [15:0]          m_out_left;
    logic signed [15:0]          m_out_right;
    logic                        m_last_of_run;
    logic                        m_end_of_stream;

    resample_checker sb;
    bit              calm;
    int              frames_sent;
    int              stream_left;
    int              idle_cycles;
    int              stall_left;

    linear_interp_resampler_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_left   (s_sample_left),
        .s_sample_right  (s_sample_right),
        .s_last_frame    (s_last_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_stream (m_end_of_stream)
    );

    always #1 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 16'sh7fff;
        end else if (r < 20) begin
            return 16'sh8000;
        end else if (r < 30) begin
            return 16'($signed($urandom_range(0, 64)) - 32);
        end
        return 16'($urandom);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_register(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] step, logic [CHAN_W-1:0] chans);
        logic [CFG_DATA_W-1:0] chan_word;
        chan_word = CFG_DATA_W'($urandom);
        chan_word[CHAN_W-1:0] = chans;
        write_reg(CFG_STEP_RATIO, step);
        write_reg(CFG_CHANNELS, chan_word);
    endtask

    task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic lst);
        int gap;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_left  <= l;
        s_sample_right <= r;
        s_last_frame   <= lst;
        do @(posedge aclk); while (!s_ready);
        frames_sent++;
    endtask

    // idle the input and let every pending word and any silent work finish
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic random_phase();
        int                    r;
        int                    count;
        logic [CFG_DATA_W-1:0] step;
        logic [CHAN_W-1:0]     chans;
        logic                  lst;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            step = CFG_DATA_W'($urandom_range(55000, 76000));
        end else if (r < 60) begin
            step = CFG_DATA_W'($urandom_range(1024, 16384));
        end else if (r < 80) begin
            step = CFG_DATA_W'($urandom_range(65536, 1048576));
        end else if (r < 88) begin
            step = CFG_DATA_W'($urandom_range(0, 1023));
        end else if (r < 94) begin
            step = CFG_DATA_W'($urandom_range(1048577, 2097151));
        end else if (r < 97) begin
            step = 21'd1024;
        end else begin
            step = 21'd1048576;
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            chans = 2'd2;
        end else if (r < 80) begin
            chans = CHAN_MONO;
        end else if (r < 90) begin
            chans = 2'd0;
        end else begin
            chans = 2'd3;
        end
        configure(step, chans);
        calm  = ($urandom_range(0, 3) == 0);
        count = $urandom_range(6, 24);
        repeat (count) begin
            if (stream_left == 0) begin
                stream_left = $urandom_range(1, 10);
            end
            lst = (stream_left == 1);
            stream_left--;
            // broken streams: a stray or missing end mark
            if ($urandom_range(0, 99) < 8) begin
                lst = ~lst;
            end
            send_frame(pick_sample(), pick_sample(), lst);
        end
        drain();
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_frame(s_sample_left, s_sample_right, s_last_frame);
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_out_left, m_out_right, m_last_of_run, m_end_of_stream);
            end
        end
    end

    initial begin
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready    <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    initial begin
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb          = new();
        calm        = 1'b0;
        frames_sent = 0;
        stream_left = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: unity step, stereo
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b1);
        send_frame(-16'sd1, 16'sd1, 1'b1);
        drain();

        // densest step, tail cut at the result cap
        configure(21'd1024, 2'd2);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sd1234, -16'sd4321, 1'b1);
        drain();

        // zero step uses the floor, mono
        configure(21'd0, CHAN_MONO);
        send_frame(16'sd100, 16'sd555, 1'b0);
        send_frame(-16'sd200, 16'sh8000, 1'b0);
        send_frame(16'sh7fff, 16'sh7fff, 1'b1);
        drain();

        // widest step, final frame gives nothing
        configure(21'h1fffff, 2'd0);
        send_frame(16'sd5, 16'sd6, 1'b0);
        send_frame(-16'sd5, -16'sd6, 1'b0);
        send_frame(16'sd7, 16'sd8, 1'b1);
        drain();

        configure(21'd1048576, 2'd3);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd1, -16'sd1, 1'b0);
        send_frame(16'sd9, -16'sd9, 1'b1);
        drain();

        configure(21'd60211, 2'd2);
        send_frame(16'sd1000, -16'sd1000, 1'b0);
        send_frame(16'sd2000, -16'sd3000, 1'b0);
        send_frame(-16'sd2000, 16'sd3000, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b1);
        drain();

        while (frames_sent < RANDOM_FRAMES) begin
            random_phase();
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
